// ===== sv/assert_macros.svh =====
// Assertion helpers used by the checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, masked while reset is high.
`define ASSERT_CLK_RST(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("assertion failed");

// Clocked check that also holds across reset.
`define ASSERT_CLK(lbl, clk, prop) \
   lbl: assert property (@(posedge clk) prop) \
      else $error("assertion failed");

`endif

// ===== sv/fes_pkg.sv =====
package fes_pkg;

   localparam int unsigned DATA_W = 32;
   localparam int unsigned NUM_CFG_CHANNELS = 2;
   localparam logic [DATA_W-1:0] MIN_WHOLE = 32'd2;

   typedef enum logic [1:0] {
      MODE_START   = 2'd0,
      MODE_COMPARE = 2'd1,
      MODE_STOP    = 2'd2
   } mode_type;

   typedef enum logic [1:0] {
      REG_WHOLE_A = 2'd0,
      REG_FRAC_A  = 2'd1,
      REG_WHOLE_B = 2'd2,
      REG_FRAC_B  = 2'd3
   } reg_index_type;

   // Half-period interval after clamping, Q32.32 ticks
   typedef struct packed {
      logic [DATA_W-1:0] whole;
      logic [DATA_W-1:0] frac;
   } interval_type;

   typedef struct packed {
      logic [1:0]        mode;
      logic              chan;
      logic [DATA_W-1:0] counter_now;
   } item_type;

   typedef struct packed {
      logic              out_chan;
      logic [DATA_W-1:0] next_compare;
      logic              was_late;
      logic              is_active;
      logic [DATA_W-1:0] edges_seen;
      logic [DATA_W-1:0] late_edges;
   } result_type;

endpackage

// ===== sv/fes_csr.sv =====
module fes_csr (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [3:0]            csr_paddr,
   input  logic [31:0]           csr_pwdata,
   output logic [31:0]           csr_prdata,
   output logic                  csr_pready,
   output fes_pkg::interval_type [fes_pkg::NUM_CFG_CHANNELS-1:0] intervals
);

   logic [31:0] whole_a_ff, whole_a_in;
   logic [31:0] frac_a_ff,  frac_a_in;
   logic [31:0] whole_b_ff, whole_b_in;
   logic [31:0] frac_b_ff,  frac_b_in;
   logic        wr_en;
   fes_pkg::reg_index_type reg_idx;

   assign csr_pready = 1'b1;
   assign wr_en      = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign reg_idx    = fes_pkg::reg_index_type'(csr_paddr[3:2]);

   always_comb begin
      whole_a_in = whole_a_ff;
      frac_a_in  = frac_a_ff;
      whole_b_in = whole_b_ff;
      frac_b_in  = frac_b_ff;
      csr_prdata = '0;
      unique case (reg_idx)
         fes_pkg::REG_WHOLE_A: begin
            csr_prdata = whole_a_ff;
            if (wr_en) whole_a_in = csr_pwdata;
         end
         fes_pkg::REG_FRAC_A: begin
            csr_prdata = frac_a_ff;
            if (wr_en) frac_a_in = csr_pwdata;
         end
         fes_pkg::REG_WHOLE_B: begin
            csr_prdata = whole_b_ff;
            if (wr_en) whole_b_in = csr_pwdata;
         end
         fes_pkg::REG_FRAC_B: begin
            csr_prdata = frac_b_ff;
            if (wr_en) frac_b_in = csr_pwdata;
         end
         default: csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         whole_a_ff <= fes_pkg::MIN_WHOLE;
         frac_a_ff  <= '0;
         whole_b_ff <= fes_pkg::MIN_WHOLE;
         frac_b_ff  <= '0;
      end else begin
         whole_a_ff <= whole_a_in;
         frac_a_ff  <= frac_a_in;
         whole_b_ff <= whole_b_in;
         frac_b_ff  <= frac_b_in;
      end
   end

   // whole part below the minimum: use minimum, drop the fraction
   always_comb begin
      intervals[0].whole = (whole_a_ff < fes_pkg::MIN_WHOLE) ? fes_pkg::MIN_WHOLE : whole_a_ff;
      intervals[0].frac  = (whole_a_ff < fes_pkg::MIN_WHOLE) ? '0 : frac_a_ff;
      intervals[1].whole = (whole_b_ff < fes_pkg::MIN_WHOLE) ? fes_pkg::MIN_WHOLE : whole_b_ff;
      intervals[1].frac  = (whole_b_ff < fes_pkg::MIN_WHOLE) ? '0 : frac_b_ff;
   end

endmodule

// ===== sv/fes_core.sv =====
module fes_core #(
   parameter int NUM_CHANNELS = 2
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  fire,
   input  fes_pkg::item_type     item,
   input  fes_pkg::interval_type [fes_pkg::NUM_CFG_CHANNELS-1:0] intervals,
   output fes_pkg::result_type   result
);

   localparam int CW = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;

   logic [31:0] frac_accum_ff    [NUM_CHANNELS];
   logic [31:0] compare_value_ff [NUM_CHANNELS];
   logic [31:0] edge_total_ff    [NUM_CHANNELS];
   logic [31:0] late_total_ff    [NUM_CHANNELS];
   logic [NUM_CHANNELS-1:0] chan_active_ff;

   fes_pkg::interval_type chan_intv [NUM_CHANNELS];

   logic [31:0] frac_accum_in, compare_value_in, edge_total_in, late_total_in;
   logic        chan_active_in;
   logic        in_range;
   logic [CW-1:0] idx;
   logic [32:0] frac_sum;
   logic [31:0] step, nc, diff;
   logic        late;
   fes_pkg::interval_type intv;

   // channels past the register set run at the minimum interval
   for (genvar i = 0; i < NUM_CHANNELS; i++) begin : g_intv
      if (i < int'(fes_pkg::NUM_CFG_CHANNELS)) begin : g_cfg
         assign chan_intv[i] = intervals[i];
      end else begin : g_min
         assign chan_intv[i] = '{whole: fes_pkg::MIN_WHOLE, frac: '0};
      end
   end

   assign in_range = (NUM_CHANNELS > 1) || (item.chan == 1'b0);
   assign idx      = in_range ? CW'(item.chan) : '0;
   assign intv     = chan_intv[idx];

   assign frac_sum = {1'b0, frac_accum_ff[idx]} + {1'b0, intv.frac};
   assign step     = intv.whole + {31'd0, frac_sum[32]};
   assign nc       = compare_value_ff[idx] + step;
   assign diff     = nc - item.counter_now;

   always_comb begin
      frac_accum_in    = frac_accum_ff[idx];
      compare_value_in = compare_value_ff[idx];
      edge_total_in    = edge_total_ff[idx];
      late_total_in    = late_total_ff[idx];
      chan_active_in   = chan_active_ff[idx];
      late             = 1'b0;
      unique case (fes_pkg::mode_type'(item.mode))
         fes_pkg::MODE_START: begin
            // accumulator restarts from zero, so the first add never carries
            frac_accum_in    = intv.frac;
            compare_value_in = item.counter_now + intv.whole;
            edge_total_in    = '0;
            late_total_in    = '0;
            chan_active_in   = 1'b1;
         end
         fes_pkg::MODE_COMPARE: begin
            if (chan_active_ff[idx]) begin
               frac_accum_in = frac_sum[31:0];
               late          = (diff == '0) || diff[31];
               compare_value_in = late ? (item.counter_now + step) : nc;
               late_total_in = late_total_ff[idx] + {31'd0, late};
               edge_total_in = edge_total_ff[idx] + 32'd1;
            end
         end
         fes_pkg::MODE_STOP: begin
            chan_active_in = 1'b0;
            edge_total_in  = '0;
            late_total_in  = '0;
         end
         default: late = 1'b0;
      endcase
   end

   always_comb begin
      result.out_chan = item.chan;
      if (in_range) begin
         result.next_compare = compare_value_in;
         result.was_late     = late;
         result.is_active    = chan_active_in;
         result.edges_seen   = edge_total_in;
         result.late_edges   = late_total_in;
      end else begin
         result.next_compare = '0;
         result.was_late     = 1'b0;
         result.is_active    = 1'b0;
         result.edges_seen   = '0;
         result.late_edges   = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         chan_active_ff <= '0;
         for (int i = 0; i < NUM_CHANNELS; i++) begin
            frac_accum_ff[i]    <= '0;
            compare_value_ff[i] <= '0;
            edge_total_ff[i]    <= '0;
            late_total_ff[i]    <= '0;
         end
      end else if (fire && in_range) begin
         frac_accum_ff[idx]    <= frac_accum_in;
         compare_value_ff[idx] <= compare_value_in;
         edge_total_ff[idx]    <= edge_total_in;
         late_total_ff[idx]    <= late_total_in;
         chan_active_ff[idx]   <= chan_active_in;
      end
   end

endmodule

// ===== sv/fractional_edge_scheduler_unit.sv =====
// A request goes through the input register and then the result register before
//   rsp_tvalid rises; it waits in the input register while the result slot stalls.
// Throughput: one request per cycle unless stalled; channel state and the result
//   register load together, so back-to-back requests to one channel see fresh state.
// Reset (synchronous, active high): channels inactive, all counters and compare values
//   zero, whole intervals 2, fractions 0, both pipeline registers empty.
module fractional_edge_scheduler_unit #(
   parameter int NUM_CHANNELS = 2
) (
   input  logic         clock,
   input  logic         reset,
   // request: tuser = mode[1:0], chan[2]; tdata = counter_now[31:0]
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [31:0]  req_tdata,
   input  logic [2:0]   req_tuser,
   // result: tuser = out_chan[0]
   // tdata = next_compare[31:0], was_late[32], is_active[33],
   //         edges_seen[65:34], late_edges[97:66], zero pad [103:98]
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [103:0] rsp_tdata,
   output logic [0:0]   rsp_tuser,
   // configuration
   input  logic         csr_psel,
   input  logic         csr_penable,
   input  logic         csr_pwrite,
   input  logic [3:0]   csr_paddr,
   input  logic [31:0]  csr_pwdata,
   output logic [31:0]  csr_prdata,
   output logic         csr_pready
);

   fes_pkg::item_type   in_ff, in_in;
   logic                in_valid_ff, in_valid_in;
   fes_pkg::result_type out_ff, out_in;
   logic                out_valid_ff, out_valid_in;
   fes_pkg::result_type core_result;
   fes_pkg::interval_type [fes_pkg::NUM_CFG_CHANNELS-1:0] intervals;
   logic                advance;
   logic                req_fire;

   // Input stage moves into the result register when the result slot is
   // empty or being drained this cycle.
   assign advance    = in_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;
   assign req_fire   = req_tvalid && req_tready;

   always_comb begin
      in_in        = in_ff;
      in_valid_in  = in_valid_ff && !advance;
      if (req_fire) begin
         in_in.mode        = req_tuser[1:0];
         in_in.chan        = req_tuser[2];
         in_in.counter_now = req_tdata;
         in_valid_in       = 1'b1;
      end
      out_in       = advance ? core_result : out_ff;
      out_valid_in = advance || (out_valid_ff && !rsp_tready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // payload needs no reset
   always_ff @(posedge clock) begin
      in_ff  <= in_in;
      out_ff <= out_in;
   end

   fes_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .intervals   (intervals)
   );

   // Channel state lives here; updated on each advance of an in-range channel.
   fes_core #(
      .NUM_CHANNELS (NUM_CHANNELS)
   ) u_core (
      .clock     (clock),
      .reset     (reset),
      .fire      (advance),
      .item      (in_ff),
      .intervals (intervals),
      .result    (core_result)
   );

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tuser  = out_ff.out_chan;
   assign rsp_tdata  = {6'd0, out_ff.late_edges, out_ff.edges_seen, out_ff.is_active,
                        out_ff.was_late, out_ff.next_compare};

endmodule

// ===== sv/fes_checker.sv =====
`include "assert_macros.svh"

module fes_checker (
   input logic         clock,
   input logic         reset,
   input logic         req_tready,
   input logic         rsp_tvalid,
   input logic         rsp_tready,
   input logic [103:0] rsp_tdata,
   input logic [0:0]   rsp_tuser
);

   logic        was_late;
   logic        is_active;
   logic [31:0] edges_seen;
   logic [31:0] late_edges;
   logic        rsp_stall;
   logic        counts_clear;
   logic [104:0] rsp_word;

   assign was_late     = rsp_tdata[32];
   assign is_active    = rsp_tdata[33];
   assign edges_seen   = rsp_tdata[65:34];
   assign late_edges   = rsp_tdata[97:66];
   assign rsp_stall    = rsp_tvalid && !rsp_tready;
   assign counts_clear = (edges_seen == 32'd0) && (late_edges == 32'd0) && !was_late;
   assign rsp_word     = {rsp_tuser, rsp_tdata};

   // stalled result holds
   `ASSERT_CLK_RST(a_rsp_hold, clock, reset, rsp_stall |=> rsp_tvalid && $stable(rsp_word))

   // pipeline empties on reset
   `ASSERT_CLK(a_reset_empty, clock, reset |=> !rsp_tvalid)

   // with the result slot free the block always takes a request
   `ASSERT_CLK_RST(a_ready_when_empty, clock, reset, !rsp_tvalid |-> req_tready)

   // an inactive channel carries no counts, and lateness needs an armed channel
   `ASSERT_CLK_RST(a_inactive_clear, clock, reset, rsp_tvalid && !is_active |-> counts_clear)

endmodule

bind fractional_edge_scheduler_unit fes_checker u_fes_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);
